>>> design/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants of the sorted key table: command and status
// codes, transaction structs and the control struct broadcast to the cells.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int KEY_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] key;
        logic [4:0]  position;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] found_index;
        logic [5:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic       ins_en;
        logic       del_en;
        logic [4:0] position;
    } ctrl_t;

endpackage

>>> design/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the table: holds a key, compares it with the broadcast key and
// shifts up or down with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module skt_cell
    import skt_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int CNT_W     = 6,
    parameter int INDEX     = 0
)
(
    input  logic                 clk,
    input  ctrl_t                ctrl,
    input  logic [KEY_WIDTH-1:0] key_in,
    input  logic [CNT_W-1:0]     count,
    input  logic [KEY_WIDTH-1:0] prev_key,
    input  logic                 prev_le,
    input  logic                 prev_match,
    input  logic [KEY_WIDTH-1:0] next_key,
    output logic [KEY_WIDTH-1:0] key_q,
    output logic                 le,
    output logic                 match,
    output logic                 ins_hit,
    output logic                 find_hit
);

    logic                 slot_valid;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;

    assign slot_valid = 32'(INDEX) < 32'(count);
    assign le         = slot_valid && (key_reg <= key_in);
    assign match      = slot_valid && (key_reg == key_in);
    assign ins_hit    = !le && prev_le;
    assign find_hit   = match && !prev_match;
    assign key_q      = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins_en)
        begin
            if (ins_hit)
            begin
                key_next = key_in;
            end
            else if (!prev_le)
            begin
                key_next = prev_key;
            end
        end
        else if (ctrl.del_en && (32'(ctrl.position) <= 32'(INDEX)))
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

>>> design/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Ascending table of up to DEPTH keys held in a row of compare-and-shift
// cells, with insert, delete-at-position and find commands.
// ----------------------------------------------------------------------------
// A command is taken on every clock edge where start is high; busy never
// rises, so one transaction can follow another in back-to-back cycles. All
// cells compare their key with the command key in the cycle the transaction
// is taken and shift at that edge; the result appears on result with done
// high in the following cycle. The receiver cannot stall and must take the
// result in that cycle. Entries above the fill count hold stale data and
// are never reported, so no clearing pass follows reset.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 done_reg;
    rsp_t                 result_reg;
    rsp_t                 result_next;
    ctrl_t                ctrl;
    logic [KEY_WIDTH-1:0] key_in;
    logic                 accept;
    logic                 full;
    logic                 pos_ok;

    logic [KEY_WIDTH-1:0] key_q    [DEPTH];
    logic [DEPTH-1:0]     le;
    logic [DEPTH-1:0]     match;
    logic [DEPTH-1:0]     ins_hit;
    logic [DEPTH-1:0]     find_hit;
    logic [IDX_W-1:0]     ins_idx;
    logic [IDX_W-1:0]     find_idx;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign key_in = KEY_WIDTH'(request.key);
    assign full   = count_reg >= CNT_W'(DEPTH);
    assign pos_ok = 32'(request.position) < 32'(count_reg);

    assign ctrl.ins_en   = accept && (request.cmd == CMD_INSERT) && !full;
    assign ctrl.del_en   = accept && (request.cmd == CMD_DELETE) && pos_ok;
    assign ctrl.position = request.position;

    // cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] prev_key;
        logic                 prev_le;
        logic                 prev_match;
        logic [KEY_WIDTH-1:0] next_key;

        if (i == 0)
        begin : g_head
            assign prev_key   = key_in;
            assign prev_le    = 1'b1;
            assign prev_match = 1'b0;
        end
        else
        begin : g_body
            assign prev_key   = key_q[i-1];
            assign prev_le    = le[i-1];
            assign prev_match = match[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_key = key_q[i];
        end
        else
        begin : g_link
            assign next_key = key_q[i+1];
        end

        skt_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .INDEX     (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .key_in     (key_in),
            .count      (count_reg),
            .prev_key   (prev_key),
            .prev_le    (prev_le),
            .prev_match (prev_match),
            .next_key   (next_key),
            .key_q      (key_q[i]),
            .le         (le[i]),
            .match      (match[i]),
            .ins_hit    (ins_hit[i]),
            .find_hit   (find_hit[i])
        );
    end

    // boundaries are one-hot, so an or of the hit indexes encodes them
    always_comb
    begin
        ins_idx  = '0;
        find_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ins_hit[i])
            begin
                ins_idx = ins_idx | IDX_W'(i);
            end
            if (find_hit[i])
            begin
                find_idx = find_idx | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.del_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        result_next.status      = ST_OK;
        result_next.found_index = '0;
        result_next.entry_count = 6'(count_next);
        case (request.cmd)
            CMD_INSERT:
            begin
                if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    result_next.found_index = 5'(ins_idx);
                end
            end
            CMD_DELETE:
            begin
                if (!pos_ok)
                begin
                    result_next.status = ST_RANGE;
                end
                else
                begin
                    result_next.found_index = request.position;
                end
            end
            CMD_FIND:
            begin
                if (|find_hit)
                begin
                    result_next.found_index = 5'(find_idx);
                end
                else
                begin
                    result_next.status = ST_MISSING;
                end
            end
            default:
            begin
                result_next.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(DEPTH))
        else $error("fill count above table depth");

    a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("fill count changed without a transaction");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |-> (32'(count_reg) == 32'(DEPTH)))
        else $error("full reported while table has room");

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("transaction without result");

endmodule

>>> verif/tb_sorted_key_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_table
// Self-checking bench for the sorted key table. A directed table of inserts,
// deletes, finds and no-ops runs first, some rows with hand-written results;
// then phases of random traffic, biased to fill, drain or churn the table, are
// sent in bursts with random gaps. Every accepted transaction runs through a
// shadow copy of the table, and each strobed result is compared against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_sorted_key_table;
    import skt_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int RANDOM_OPS   = 1950;
    localparam int STALL_LIMIT  = 2000;

    typedef struct {
        req_t req;
        bit   pinned;
        rsp_t rsp;
    } step_t;

    typedef struct {
        bit   pinned;
        rsp_t rsp;
    } pin_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t request = '0;
    logic done;
    rsp_t result;

    logic [15:0] shadow_keys [TABLE_DEPTH];
    int          shadow_fill = 0;
    rsp_t        rsp_expect_q [$];
    pin_t        pin_q [$];
    logic [15:0] key_pool [16];

    int errors = 0;
    int idle_cycles = 0;
    int n_ops = 0;
    int n_ins = 0;
    int n_del = 0;
    int n_find = 0;
    int n_full = 0;
    int n_range = 0;
    int n_missing = 0;

    sorted_key_table i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // shadow table: applies one operation and returns the expected result
    function automatic rsp_t predict_table_op(req_t r);
        rsp_t o;
        int   pos;
        int   i;
        o.status      = ST_OK;
        o.found_index = '0;
        case (cmd_t'(r.cmd))
            CMD_INSERT:
            begin
                if (shadow_fill >= TABLE_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < shadow_fill && shadow_keys[pos] <= r.key)
                        pos++;
                    for (i = shadow_fill; i > pos; i--)
                        shadow_keys[i] = shadow_keys[i - 1];
                    shadow_keys[pos] = r.key;
                    shadow_fill++;
                    o.found_index = pos[4:0];
                end
            end
            CMD_DELETE:
            begin
                if (r.position >= shadow_fill)
                    o.status = ST_RANGE;
                else
                begin
                    for (i = r.position; i + 1 < shadow_fill; i++)
                        shadow_keys[i] = shadow_keys[i + 1];
                    shadow_fill--;
                    o.found_index = r.position;
                end
            end
            CMD_FIND:
            begin
                o.status = ST_MISSING;
                for (i = 0; i < shadow_fill; i++)
                begin
                    if (shadow_keys[i] == r.key)
                    begin
                        o.status      = ST_OK;
                        o.found_index = i[4:0];
                        break;
                    end
                    if (shadow_keys[i] > r.key)
                        break;
                end
            end
            default: ;
        endcase
        o.entry_count = shadow_fill[5:0];
        return o;
    endfunction

    function automatic step_t step_row(cmd_t c, logic [15:0] k, logic [4:0] p, bit pin,
                                       status_t s, int idx, int cnt);
        step_t t;
        t.req.cmd             = c;
        t.req.key             = k;
        t.req.position        = p;
        t.pinned              = pin;
        t.rsp.status          = s;
        t.rsp.found_index     = idx[4:0];
        t.rsp.entry_count     = cnt[5:0];
        return t;
    endfunction

    // result check and prediction on every accepted transaction
    always @(posedge clk)
    begin
        rsp_t e;
        pin_t p;
        if (rst_n)
        begin
            if (done)
            begin
                if (rsp_expect_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: status %0d index %0d count %0d",
                             $time, result.status, result.found_index, result.entry_count);
                    errors++;
                end
                else
                begin
                    e = rsp_expect_q.pop_front();
                    if (result.status !== e.status || result.found_index !== e.found_index
                        || result.entry_count !== e.entry_count)
                    begin
                        $display("%0t: mismatch expected status %0d index %0d count %0d, actual status %0d index %0d count %0d",
                                 $time, e.status, e.found_index, e.entry_count,
                                 result.status, result.found_index, result.entry_count);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                p = pin_q.pop_front();
                e = predict_table_op(request);
                if (p.pinned)
                    e = p.rsp;
                rsp_expect_q.push_back(e);
                n_ops++;
                case (cmd_t'(request.cmd))
                    CMD_INSERT: n_ins++;
                    CMD_DELETE: n_del++;
                    CMD_FIND:   n_find++;
                    default: ;
                endcase
                case (status_t'(e.status))
                    ST_FULL:    n_full++;
                    ST_RANGE:   n_range++;
                    ST_MISSING: n_missing++;
                    default: ;
                endcase
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("tb_sorted_key_table NOT OK");
                $finish;
            end
        end
    end

    task automatic send_op(req_t r, bit pin, rsp_t rsp);
        pin_t p;
        p.pinned = pin;
        p.rsp    = rsp;
        pin_q.push_back(p);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_for(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    initial
    begin
        step_t       steps [$];
        req_t        r;
        rsp_t        none;
        int          mode;
        int          phase_left;
        int          burst_left;
        int          pick;
        int          ksel;
        logic [15:0] k;

        none = '0;
        foreach (key_pool[i])
            key_pool[i] = 16'(i * 4099);

        steps.push_back(step_row(CMD_FIND,   16'h0000, 5'd0,  1, ST_MISSING, 0, 0));
        steps.push_back(step_row(CMD_DELETE, 16'h0000, 5'd0,  1, ST_RANGE,   0, 0));
        steps.push_back(step_row(CMD_NOP,    16'hffff, 5'd31, 1, ST_OK,      0, 0));
        steps.push_back(step_row(CMD_INSERT, 16'hffff, 5'd31, 1, ST_OK,      0, 1));
        steps.push_back(step_row(CMD_INSERT, 16'h0000, 5'd0,  1, ST_OK,      0, 2));
        steps.push_back(step_row(CMD_FIND,   16'hffff, 5'd0,  1, ST_OK,      1, 2));
        steps.push_back(step_row(CMD_INSERT, 16'h8000, 5'd0,  1, ST_OK,      1, 3));
        steps.push_back(step_row(CMD_INSERT, 16'h8000, 5'd0,  1, ST_OK,      2, 4));
        steps.push_back(step_row(CMD_FIND,   16'h8000, 5'd0,  1, ST_OK,      1, 4));
        steps.push_back(step_row(CMD_INSERT, 16'h0000, 5'd0,  1, ST_OK,      1, 5));
        steps.push_back(step_row(CMD_FIND,   16'h7fff, 5'd0,  1, ST_MISSING, 0, 5));
        steps.push_back(step_row(CMD_DELETE, 16'hffff, 5'd31, 1, ST_RANGE,   0, 5));
        steps.push_back(step_row(CMD_DELETE, 16'h0000, 5'd5,  1, ST_RANGE,   0, 5));
        steps.push_back(step_row(CMD_DELETE, 16'h0000, 5'd4,  1, ST_OK,      4, 4));
        steps.push_back(step_row(CMD_FIND,   16'hffff, 5'd0,  1, ST_MISSING, 0, 4));
        steps.push_back(step_row(CMD_NOP,    16'h5555, 5'd10, 1, ST_OK,      0, 4));
        steps.push_back(step_row(CMD_INSERT, 16'h5555, 5'd0,  0, ST_OK,      0, 0));
        steps.push_back(step_row(CMD_DELETE, 16'h0000, 5'd0,  1, ST_OK,      0, 4));
        steps.push_back(step_row(CMD_FIND,   16'h0000, 5'd0,  1, ST_OK,      0, 4));
        steps.push_back(step_row(CMD_INSERT, 16'haaaa, 5'd0,  0, ST_OK,      0, 0));
        steps.push_back(step_row(CMD_DELETE, 16'h0000, 5'd2,  0, ST_OK,      0, 0));
        steps.push_back(step_row(CMD_FIND,   16'h8000, 5'd0,  0, ST_OK,      0, 0));
        steps.push_back(step_row(CMD_FIND,   16'haaaa, 5'd0,  0, ST_OK,      0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (steps[i])
        begin
            send_op(steps[i].req, steps[i].pinned, steps[i].rsp);
            if (i % 5 == 4)
                idle_for($urandom_range(1, 3));
        end

        // fill, drain and mixed phases so the table hits both empty and full
        mode       = 0;
        phase_left = 0;
        burst_left = 0;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (phase_left == 0)
            begin
                mode       = $urandom_range(0, 2);
                phase_left = $urandom_range(64, 160);
            end
            phase_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 48);
                if ($urandom_range(0, 3) != 0)
                    idle_for($urandom_range(1, 5));
            end
            burst_left--;

            pick = $urandom_range(0, 99);
            case (mode)
                0:       r.cmd = pick < 70 ? CMD_INSERT : pick < 80 ? CMD_DELETE :
                                 pick < 97 ? CMD_FIND : CMD_NOP;
                1:       r.cmd = pick < 25 ? CMD_INSERT : pick < 75 ? CMD_DELETE :
                                 pick < 97 ? CMD_FIND : CMD_NOP;
                default: r.cmd = pick < 40 ? CMD_INSERT : pick < 60 ? CMD_DELETE :
                                 pick < 97 ? CMD_FIND : CMD_NOP;
            endcase

            ksel = $urandom_range(0, 9);
            if (ksel <= 3 || ksel == 9)
                k = 16'($urandom_range(0, 65535));
            else if (ksel <= 6)
                k = key_pool[$urandom_range(0, 15)];
            else if (ksel == 7)
                k = 16'($urandom_range(0, 15));
            else
                k = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            r.key = k;
            if (cmd_t'(r.cmd) == CMD_INSERT)
                key_pool[$urandom_range(0, 15)] = k;

            if ($urandom_range(0, 1) == 0)
                r.position = 5'($urandom_range(0, mode == 1 ? 3 : 15));
            else
                r.position = 5'($urandom_range(0, 31));

            send_op(r, 1'b0, none);
        end

        start <= 1'b0;
        while (pin_q.size() != 0 || rsp_expect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("ran %0d transactions: %0d inserts, %0d deletes, %0d finds",
                 n_ops, n_ins, n_del, n_find);
        $display("saw %0d table full, %0d out of range, %0d not found, %0d errors",
                 n_full, n_range, n_missing, errors);
        if (errors == 0)
            $display("tb_sorted_key_table OK");
        else
            $display("tb_sorted_key_table NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
design/skt_pkg.sv
design/skt_cell.sv
design/sorted_key_table.sv
verif/tb_sorted_key_table.sv
